// ----- design/mbt_pkg.sv -----
// shared types, constants and helpers for the backprop train step unit
// no dependencies
`default_nettype none

package mbt_pkg;

	localparam int HIDDEN_COUNT_DEF = 2;
	localparam int SIG_DEPTH_DEF    = 256;
	localparam int JIDX_W           = 3;
	localparam logic [15:0] LR_RESET = 16'd655;
	localparam longint EXP_NEG1_Q30 = 64'sd395007542;
	localparam longint Q30_ONE      = 64'sd1 <<< 30;

	typedef enum logic [4:0] {
		OP_WRITE,
		OP_READ,
		OP_FH_INIT,
		OP_FH_XW,
		OP_FH_SIG,
		OP_FO_INIT,
		OP_FO_AW,
		OP_FO_SIG,
		OP_SQ,
		OP_DP,
		OP_DOUT,
		OP_HERR,
		OP_DA,
		OP_HD,
		OP_UBO,
		OP_UAD,
		OP_UWO,
		OP_UBH,
		OP_UXH,
		OP_UWH
	} op_t;

	localparam logic [1:0] FUNC_WRITE   = 2'd0;
	localparam logic [1:0] FUNC_READ    = 2'd1;
	localparam logic [1:0] FUNC_TRAIN   = 2'd2;
	localparam logic [1:0] FUNC_PREDICT = 2'd3;

	typedef struct packed {
		op_t               op;
		logic [JIDX_W-1:0] j;
		logic              k;
		logic              issue;
		logic              wb;
		logic              load_out;
		logic              accept;
	} cmd_t;

	function automatic logic signed [23:0] sat24(input logic signed [42:0] v);
		logic signed [23:0] r;
		if (v > 43'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -43'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = 24'(v);
		end
		return r;
	endfunction

	// scales a q2.30 value by exp(-1) cnt times
	function automatic longint exp_scale(input longint s, input longint cnt);
		longint r;
		r = s;
		for (longint n = 0; n < cnt; n++) begin
			r = (r * EXP_NEG1_Q30) >>> 30;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/mbt_if.sv -----
// request, result and configuration channel interfaces
// no dependencies
`default_nettype none

interface mbt_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [3:0]         weight_index;
	logic signed [23:0] weight_value;
	logic signed [23:0] sample_x0;
	logic signed [23:0] sample_x1;
	logic [16:0]        target;
	modport source (output valid, func, weight_index, weight_value, sample_x0, sample_x1,
		target, input ready);
	modport sink (input valid, func, weight_index, weight_value, sample_x0, sample_x1,
		target, output ready);
endinterface

interface mbt_out_if;
	logic               valid;
	logic               ready;
	logic [16:0]        prediction;
	logic [16:0]        squared_error;
	logic signed [23:0] read_value;
	modport source (output valid, prediction, squared_error, read_value, input ready);
	modport sink (input valid, prediction, squared_error, read_value, output ready);
endinterface

interface mbt_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- design/mbt_ctrl.sv -----
// sequencer for the train step unit: walks the op list for one request
// depends on mbt_pkg
`default_nettype none

module mbt_ctrl #(
	parameter int HIDDEN_COUNT = mbt_pkg::HIDDEN_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [1:0]  in_func,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output mbt_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WB, ST_FIN} state_t;

	localparam logic [mbt_pkg::JIDX_W-1:0] J_LAST = mbt_pkg::JIDX_W'(HIDDEN_COUNT - 1);

	state_t                      state_q;
	mbt_pkg::op_t                op_q, op_n;
	logic [mbt_pkg::JIDX_W-1:0]  j_q, j_n;
	logic                        k_q, k_n;
	logic                        train_q;
	logic                        out_valid_q;
	logic                        done_n;
	logic                        j_last;
	logic                        accept;
	logic                        load_out;

	assign j_last   = (j_q == J_LAST);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op       = op_q;
		cmd.j        = j_q;
		cmd.k        = k_q;
		cmd.issue    = (state_q == ST_ISSUE);
		cmd.wb       = (state_q == ST_WB);
		cmd.load_out = load_out;
		cmd.accept   = accept;
	end

	always_comb begin
		op_n   = op_q;
		j_n    = j_q;
		k_n    = 1'b0;
		done_n = 1'b0;
		case (op_q)
			mbt_pkg::OP_WRITE, mbt_pkg::OP_READ: begin
				done_n = 1'b1;
			end
			mbt_pkg::OP_FH_INIT: begin
				op_n = mbt_pkg::OP_FH_XW;
			end
			mbt_pkg::OP_FH_XW: begin
				if (!k_q) begin
					k_n = 1'b1;
				end else begin
					op_n = mbt_pkg::OP_FH_SIG;
				end
			end
			mbt_pkg::OP_FH_SIG: begin
				if (j_last) begin
					op_n = mbt_pkg::OP_FO_INIT;
					j_n  = '0;
				end else begin
					op_n = mbt_pkg::OP_FH_INIT;
					j_n  = j_q + 1'b1;
				end
			end
			mbt_pkg::OP_FO_INIT: begin
				op_n = mbt_pkg::OP_FO_AW;
			end
			mbt_pkg::OP_FO_AW: begin
				if (j_last) begin
					op_n = mbt_pkg::OP_FO_SIG;
					j_n  = '0;
				end else begin
					j_n = j_q + 1'b1;
				end
			end
			mbt_pkg::OP_FO_SIG: begin
				if (train_q) begin
					op_n = mbt_pkg::OP_SQ;
				end else begin
					done_n = 1'b1;
				end
			end
			mbt_pkg::OP_SQ:   op_n = mbt_pkg::OP_DP;
			mbt_pkg::OP_DP:   op_n = mbt_pkg::OP_DOUT;
			mbt_pkg::OP_DOUT: begin
				op_n = mbt_pkg::OP_HERR;
				j_n  = '0;
			end
			mbt_pkg::OP_HERR: op_n = mbt_pkg::OP_DA;
			mbt_pkg::OP_DA:   op_n = mbt_pkg::OP_HD;
			mbt_pkg::OP_HD: begin
				if (j_last) begin
					op_n = mbt_pkg::OP_UBO;
					j_n  = '0;
				end else begin
					op_n = mbt_pkg::OP_HERR;
					j_n  = j_q + 1'b1;
				end
			end
			mbt_pkg::OP_UBO: begin
				op_n = mbt_pkg::OP_UAD;
				j_n  = '0;
			end
			mbt_pkg::OP_UAD:  op_n = mbt_pkg::OP_UWO;
			mbt_pkg::OP_UWO: begin
				if (j_last) begin
					op_n = mbt_pkg::OP_UBH;
					j_n  = '0;
				end else begin
					op_n = mbt_pkg::OP_UAD;
					j_n  = j_q + 1'b1;
				end
			end
			mbt_pkg::OP_UBH:  op_n = mbt_pkg::OP_UXH;
			mbt_pkg::OP_UXH: begin
				op_n = mbt_pkg::OP_UWH;
				k_n  = k_q;
			end
			mbt_pkg::OP_UWH: begin
				if (!k_q) begin
					op_n = mbt_pkg::OP_UXH;
					k_n  = 1'b1;
				end else if (j_last) begin
					done_n = 1'b1;
				end else begin
					op_n = mbt_pkg::OP_UBH;
					j_n  = j_q + 1'b1;
				end
			end
			default: begin
				done_n = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= mbt_pkg::OP_WRITE;
			j_q         <= '0;
			k_q         <= 1'b0;
			train_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						j_q     <= '0;
						k_q     <= 1'b0;
						train_q <= (in_func == mbt_pkg::FUNC_TRAIN);
						case (in_func)
							mbt_pkg::FUNC_WRITE: op_q <= mbt_pkg::OP_WRITE;
							mbt_pkg::FUNC_READ:  op_q <= mbt_pkg::OP_READ;
							default:             op_q <= mbt_pkg::OP_FH_INIT;
						endcase
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (done_n) begin
						state_q <= ST_FIN;
					end else begin
						op_q    <= op_n;
						j_q     <= j_n;
						k_q     <= k_n;
						state_q <= ST_ISSUE;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/mbt_datapath.sv -----
// weight store, shared multiplier, sigmoid table and result registers
// depends on mbt_pkg, driven by mbt_ctrl commands
`default_nettype none

module mbt_datapath #(
	parameter int HIDDEN_COUNT        = mbt_pkg::HIDDEN_COUNT_DEF,
	parameter int SIGMOID_TABLE_DEPTH = mbt_pkg::SIG_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mbt_pkg::cmd_t      cmd,
	input  wire logic [3:0]         weight_index,
	input  wire logic signed [23:0] weight_value,
	input  wire logic signed [23:0] sample_x0,
	input  wire logic signed [23:0] sample_x1,
	input  wire logic [16:0]        target,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_data,
	output logic [16:0]             prediction,
	output logic [16:0]             squared_error,
	output logic signed [23:0]      read_value
);

	localparam int H   = HIDDEN_COUNT;
	localparam int D   = SIGMOID_TABLE_DEPTH;
	localparam int JW  = (H > 1) ? $clog2(H) : 1;
	localparam int HWB = $clog2(2 * H);
	localparam int IW  = $clog2(D);

	logic signed [23:0] w_hid_q [2*H];
	logic signed [23:0] b_hid_q [H];
	logic signed [23:0] w_out_q [H];
	logic signed [23:0] b_out_q;
	logic [15:0]        lr_q;

	logic [3:0]         widx_q;
	logic signed [23:0] wval_q;
	logic signed [23:0] x0_q, x1_q;
	logic [16:0]        target_q;

	logic signed [33:0] acc_q;
	logic [16:0]        act_q [H];
	logic signed [23:0] hd_q [H];
	logic [16:0]        pred_q;
	logic [16:0]        sq_q;
	logic signed [23:0] rd_q;
	logic signed [17:0] err_q;
	logic signed [17:0] dout_q;
	logic signed [32:0] t_q;
	logic signed [25:0] u_q;
	logic [16:0]        sig_q;
	logic signed [57:0] prod_q;

	logic [16:0]        out_pred_q, out_sq_q;
	logic signed [23:0] out_rd_q;

	logic [JW-1:0]      jj;
	logic [HWB-1:0]     wh_idx;
	logic signed [23:0] xk;
	logic signed [32:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [41:0] rnd_w;
	logic signed [17:0] e_w;
	logic [19:0]        zoff;
	logic [32:0]        sidx_m;
	logic [12:0]        sidx;
	logic [IW-1:0]      sidx_c;
	logic [16:0]        sig_rom [D];

	logic [5:0]         wi;
	logic [5:0]         wi_b, wi_o;
	logic               wi_hw, wi_hb, wi_ow, wi_ob;

	// sigmoid(-8 + 16*i/D) in q0.16, from an integer exp series in q2.30
	genvar gi;
	generate
		for (gi = 0; gi < D; gi++) begin : g_rom
			localparam longint N   = 64'sd16 * longint'(gi) - 64'sd8 * longint'(D);
			localparam longint AN  = (N < 0) ? -N : N;
			localparam longint Q   = AN / longint'(D);
			localparam longint F   = ((AN % longint'(D)) <<< 30) / longint'(D);
			localparam longint T1  = F;
			localparam longint T2  = ((T1 * F) >>> 30) / 2;
			localparam longint T3  = ((T2 * F) >>> 30) / 3;
			localparam longint T4  = ((T3 * F) >>> 30) / 4;
			localparam longint T5  = ((T4 * F) >>> 30) / 5;
			localparam longint T6  = ((T5 * F) >>> 30) / 6;
			localparam longint T7  = ((T6 * F) >>> 30) / 7;
			localparam longint T8  = ((T7 * F) >>> 30) / 8;
			localparam longint T9  = ((T8 * F) >>> 30) / 9;
			localparam longint T10 = ((T9 * F) >>> 30) / 10;
			localparam longint T11 = ((T10 * F) >>> 30) / 11;
			localparam longint T12 = ((T11 * F) >>> 30) / 12;
			localparam longint T13 = ((T12 * F) >>> 30) / 13;
			localparam longint T14 = ((T13 * F) >>> 30) / 14;
			localparam longint SER = mbt_pkg::Q30_ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7
				+ T8 - T9 + T10 - T11 + T12 - T13 + T14;
			localparam longint EX  = mbt_pkg::exp_scale(SER, Q);
			localparam longint DEN = mbt_pkg::Q30_ONE + EX;
			localparam longint NUM = (N >= 0) ? (64'sd65536 <<< 30) : (64'sd65536 * EX);
			localparam logic [16:0] ROM_VAL = 17'((NUM + DEN / 2) / DEN);
			assign sig_rom[gi] = ROM_VAL;
		end
	endgenerate

	assign jj     = cmd.j[JW-1:0];
	assign wh_idx = cmd.k ? (HWB'(H) + HWB'(jj)) : HWB'(jj);
	assign xk     = cmd.k ? x1_q : x0_q;
	assign rnd_w  = 42'((prod_q + 58'sd32768) >>> 16);
	assign e_w    = $signed({1'b0, target_q}) - $signed({1'b0, pred_q});

	// sigmoid table index with z clamped to [-8, 8)
	always_comb begin
		if (acc_q < -34'sd524288) begin
			zoff = '0;
		end else if (acc_q > 34'sd524287) begin
			zoff = 20'hFFFFF;
		end else begin
			zoff = 20'(acc_q + 34'sd524288);
		end
		sidx_m = 33'(zoff) * 33'(D);
		sidx   = sidx_m[32:20];
		if (sidx >= 13'(D)) begin
			sidx_c = IW'(D - 1);
		end else begin
			sidx_c = sidx[IW-1:0];
		end
	end

	// weight index decode
	always_comb begin
		wi    = 6'(widx_q);
		wi_b  = wi - 6'(2 * H);
		wi_o  = wi - 6'(3 * H);
		wi_hw = (wi < 6'(2 * H));
		wi_hb = !wi_hw && (wi < 6'(3 * H));
		wi_ow = !wi_hw && !wi_hb && (wi < 6'(4 * H));
		wi_ob = (wi == 6'(4 * H));
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			mbt_pkg::OP_FH_XW: begin
				mul_a = 33'(xk);
				mul_b = 25'(w_hid_q[wh_idx]);
			end
			mbt_pkg::OP_FO_AW: begin
				mul_a = $signed(33'(act_q[jj]));
				mul_b = 25'(w_out_q[jj]);
			end
			mbt_pkg::OP_SQ: begin
				mul_a = 33'(e_w);
				mul_b = 25'(e_w);
			end
			mbt_pkg::OP_DP: begin
				mul_a = $signed(33'(pred_q));
				mul_b = $signed(25'(17'h10000 - pred_q));
			end
			mbt_pkg::OP_DOUT: begin
				mul_a = 33'(err_q);
				mul_b = 25'(t_q);
			end
			mbt_pkg::OP_HERR: begin
				mul_a = 33'(dout_q);
				mul_b = 25'(w_out_q[jj]);
			end
			mbt_pkg::OP_DA: begin
				mul_a = $signed(33'(act_q[jj]));
				mul_b = $signed(25'(17'h10000 - act_q[jj]));
			end
			mbt_pkg::OP_HD: begin
				mul_a = 33'(u_q);
				mul_b = 25'(t_q);
			end
			mbt_pkg::OP_UBO: begin
				mul_a = 33'(dout_q);
				mul_b = $signed(25'(lr_q));
			end
			mbt_pkg::OP_UAD: begin
				mul_a = $signed(33'(act_q[jj]));
				mul_b = 25'(dout_q);
			end
			mbt_pkg::OP_UWO, mbt_pkg::OP_UWH: begin
				mul_a = t_q;
				mul_b = $signed(25'(lr_q));
			end
			mbt_pkg::OP_UBH: begin
				mul_a = 33'(hd_q[jj]);
				mul_b = $signed(25'(lr_q));
			end
			mbt_pkg::OP_UXH: begin
				mul_a = 33'(xk);
				mul_b = 25'(hd_q[jj]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			prod_q <= 58'(mul_a) * 58'(mul_b);
			sig_q  <= sig_rom[sidx_c];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			widx_q   <= weight_index;
			wval_q   <= weight_value;
			x0_q     <= sample_x0;
			x1_q     <= sample_x1;
			target_q <= target;
			pred_q   <= '0;
			sq_q     <= '0;
			rd_q     <= '0;
		end else if (cmd.wb) begin
			case (cmd.op)
				mbt_pkg::OP_READ: begin
					if (wi_hw) begin
						rd_q <= w_hid_q[wi[HWB-1:0]];
					end else if (wi_hb) begin
						rd_q <= b_hid_q[wi_b[JW-1:0]];
					end else if (wi_ow) begin
						rd_q <= w_out_q[wi_o[JW-1:0]];
					end else if (wi_ob) begin
						rd_q <= b_out_q;
					end else begin
						rd_q <= '0;
					end
				end
				mbt_pkg::OP_FH_INIT: acc_q <= 34'(b_hid_q[jj]);
				mbt_pkg::OP_FO_INIT: acc_q <= 34'(b_out_q);
				mbt_pkg::OP_FH_XW, mbt_pkg::OP_FO_AW: acc_q <= acc_q + 34'(rnd_w);
				mbt_pkg::OP_FH_SIG: act_q[jj] <= sig_q;
				mbt_pkg::OP_FO_SIG: pred_q <= sig_q;
				mbt_pkg::OP_SQ: begin
					err_q <= e_w;
					if (rnd_w > 42'sd131071) begin
						sq_q <= 17'h1FFFF;
					end else begin
						sq_q <= 17'(rnd_w);
					end
				end
				mbt_pkg::OP_DP, mbt_pkg::OP_DA, mbt_pkg::OP_UAD, mbt_pkg::OP_UXH: begin
					t_q <= 33'(rnd_w);
				end
				mbt_pkg::OP_DOUT: dout_q <= 18'(rnd_w);
				mbt_pkg::OP_HERR: u_q <= 26'(rnd_w);
				mbt_pkg::OP_HD:   hd_q[jj] <= mbt_pkg::sat24(43'(rnd_w));
				default: begin
				end
			endcase
		end
	end

	// weight store: host writes and gradient updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2 * H; i++) begin
				w_hid_q[i] <= '0;
			end
			for (int i = 0; i < H; i++) begin
				b_hid_q[i] <= '0;
				w_out_q[i] <= '0;
			end
			b_out_q <= '0;
			lr_q    <= mbt_pkg::LR_RESET;
		end else begin
			if (cfg_we) begin
				lr_q <= cfg_data;
			end
			if (cmd.wb) begin
				case (cmd.op)
					mbt_pkg::OP_WRITE: begin
						if (wi_hw) begin
							w_hid_q[wi[HWB-1:0]] <= wval_q;
						end else if (wi_hb) begin
							b_hid_q[wi_b[JW-1:0]] <= wval_q;
						end else if (wi_ow) begin
							w_out_q[wi_o[JW-1:0]] <= wval_q;
						end else if (wi_ob) begin
							b_out_q <= wval_q;
						end
					end
					mbt_pkg::OP_UBO: begin
						b_out_q <= mbt_pkg::sat24(43'(b_out_q) + 43'(rnd_w));
					end
					mbt_pkg::OP_UWO: begin
						w_out_q[jj] <= mbt_pkg::sat24(43'(w_out_q[jj]) + 43'(rnd_w));
					end
					mbt_pkg::OP_UBH: begin
						b_hid_q[jj] <= mbt_pkg::sat24(43'(b_hid_q[jj]) + 43'(rnd_w));
					end
					mbt_pkg::OP_UWH: begin
						w_hid_q[wh_idx] <= mbt_pkg::sat24(43'(w_hid_q[wh_idx]) + 43'(rnd_w));
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_pred_q <= pred_q;
			out_sq_q   <= sq_q;
			out_rd_q   <= rd_q;
		end
	end

	assign prediction    = out_pred_q;
	assign squared_error = out_sq_q;
	assign read_value    = out_rd_q;

endmodule

`default_nettype wire

// ----- design/mlp_backprop_train_step_unit.sv -----
// two-layer sigmoid perceptron with online backprop training, one request at a time
// each request runs as a list of ops, each issued then written back; ops = 1 for weight write/read,
// 5H+2 for predict, 15H+6 for train (H = HIDDEN_COUNT);
// the ops that multiply all share one 33x25 multiplier
// throughput: next request taken the cycle after the result register is loaded
// reset: all weights and biases clear to zero, step size register to 655, channels idle
`default_nettype none

module mlp_backprop_train_step_unit #(
	parameter int HIDDEN_COUNT        = mbt_pkg::HIDDEN_COUNT_DEF,
	parameter int SIGMOID_TABLE_DEPTH = mbt_pkg::SIG_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mbt_in_if.sink     cmd,
	mbt_out_if.source  rsp,
	mbt_cfg_if.sink    cfg
);

	mbt_pkg::cmd_t ctl_cmd;
	logic          in_ready;
	logic          out_valid;

	assign cmd.ready = in_ready;
	assign rsp.valid = out_valid;
	assign cfg.ready = 1'b1;

	mbt_ctrl #(
		.HIDDEN_COUNT(HIDDEN_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_func  (cmd.func),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(rsp.ready),
		.cmd      (ctl_cmd)
	);

	mbt_datapath #(
		.HIDDEN_COUNT       (HIDDEN_COUNT),
		.SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.weight_index (cmd.weight_index),
		.weight_value (cmd.weight_value),
		.sample_x0    (cmd.sample_x0),
		.sample_x1    (cmd.sample_x1),
		.target       (cmd.target),
		.cfg_we       (cfg.valid),
		.cfg_data     (cfg.data),
		.prediction   (rsp.prediction),
		.squared_error(rsp.squared_error),
		.read_value   (rsp.read_value)
	);

endmodule

`default_nettype wire
